// File: design/ohta_pkg.sv
// ohta_pkg: shared widths, register codes, reset values and helper functions
// for the ohta colour pixel classifier; no dependencies
`default_nettype none

package ohta_pkg;

  localparam int PIX_W   = 8;
  localparam int INT_W   = 10;
  localparam int THR_W   = 12;
  localparam int LIGHT_W = 10;
  localparam int EN_W    = 3;
  localparam int IDX_W   = 3;
  localparam int THR_N   = 6;
  localparam int D1_W    = PIX_W + 1;
  localparam int D2_W    = PIX_W + 2;
  localparam int D1SQ_W  = 2 * PIX_W;
  localparam int D2SQ_W  = 2 * PIX_W + 2;
  localparam int PROD_W  = THR_W + INT_W + 1;
  localparam int BSQ_W   = 42;
  localparam int SCALE_SH = 20;
  localparam int CMP_W   = 45;
  localparam int MASK_W  = 8;

  localparam logic [PIX_W-1:0] RG_DIFF_MAX_DEF = 8'd15;
  localparam logic [PIX_W-1:0] GB_DIFF_MAX_DEF = 8'd25;
  localparam logic [PIX_W-1:0] BR_DIFF_MAX_DEF = 8'd14;

  typedef enum logic [IDX_W-1:0] {
    REG_RED_P1_MIN        = 3'd0,
    REG_RED_P2_MAX        = 3'd1,
    REG_BLUE_P1_MAX       = 3'd2,
    REG_BLUE_P2_ABS_MAX   = 3'd3,
    REG_YELLOW_P1_MIN     = 3'd4,
    REG_YELLOW_P2_ABS_MAX = 3'd5,
    REG_LIGHT_MIN         = 3'd6,
    REG_COLOR_ENABLE      = 3'd7
  } ohta_reg_t;

  localparam int THR_RED_P1    = 0;
  localparam int THR_RED_P2    = 1;
  localparam int THR_BLUE_P1   = 2;
  localparam int THR_BLUE_P2   = 3;
  localparam int THR_YELLOW_P1 = 4;
  localparam int THR_YELLOW_P2 = 5;

  localparam int EN_RED    = 0;
  localparam int EN_BLUE   = 1;
  localparam int EN_YELLOW = 2;

  localparam logic [THR_W-1:0]   RST_RED_P1_MIN        = 12'd25;
  localparam logic [THR_W-1:0]   RST_RED_P2_MAX        = 12'hFE4;
  localparam logic [THR_W-1:0]   RST_BLUE_P1_MAX       = 12'hFD7;
  localparam logic [THR_W-1:0]   RST_BLUE_P2_ABS_MAX   = 12'd205;
  localparam logic [THR_W-1:0]   RST_YELLOW_P1_MIN     = 12'd73;
  localparam logic [THR_W-1:0]   RST_YELLOW_P2_ABS_MAX = 12'd28;
  localparam logic [LIGHT_W-1:0] RST_LIGHT_MIN         = 10'd100;
  localparam logic [EN_W-1:0]    RST_COLOR_ENABLE      = 3'd1;

  typedef struct packed {
    logic [THR_N-1:0][THR_W-1:0] thr;
    logic [LIGHT_W-1:0]          light_min;
    logic [EN_W-1:0]             enable;
  } ohta_cfg_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } ohta_cmp_t;

  function automatic logic [BSQ_W-1:0] sq_prod(input logic signed [PROD_W-1:0] x);
    logic signed [2*PROD_W-1:0] f;
    f = x * x;
    return f[BSQ_W-1:0];
  endfunction

  // sign of a - b*sqrt(k) from the operand signs and the squared magnitudes
  function automatic ohta_cmp_t root_cmp(input logic a_neg, input logic a_zero,
                                         input logic b_neg, input logic b_zero,
                                         input logic gt_mag, input logic lt_mag);
    ohta_cmp_t c;
    logic      a_pos;
    logic      b_pos;
    a_pos = !a_neg && !a_zero;
    b_pos = !b_neg && !b_zero;
    c.gt  = 1'b0;
    c.lt  = 1'b0;
    if (!(a_zero && b_zero)) begin
      if (!a_neg && !b_pos) begin
        c.gt = 1'b1;
      end else if (!a_pos && !b_neg) begin
        c.lt = 1'b1;
      end else if (a_pos) begin
        c.gt = gt_mag;
        c.lt = lt_mag;
      end else begin
        c.gt = lt_mag;
        c.lt = gt_mag;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/ohta_color_pixel_classifier.sv
// ohta_color_pixel_classifier: top level of the ohta colour pixel classifier
// depends on ohta_pkg and ohta_cfg_regs
//
// one rgb pixel comes in per transfer on in_valid/in_stall (red, green, blue)
// and one result goes out per transfer on out_valid/out_stall (mask, hit bits,
// achromatic). registers are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must write them only while no pixel is in flight, as the
// block itself does not enforce it; cfg_ready is always high.
// four register stages: differences and light test, threshold times intensity
// products, squares, then root comparison into the output register.
// throughput is one pixel per cycle while out_stall is low, set by the stage
// registers; each stage holds its item under stall and takes a new one
// whenever it is empty or its successor moves, so bubbles close up and the
// input keeps flowing while a result waits in the output register.
// synchronous reset empties the pipeline and loads the register defaults.
// when out_stall is high the result holds and the stages behind it fill up
// before in_stall rises.
`default_nettype none

module ohta_color_pixel_classifier
  import ohta_pkg::*;
#(
  parameter logic [PIX_W-1:0] RG_DIFF_MAX = RG_DIFF_MAX_DEF,
  parameter logic [PIX_W-1:0] GB_DIFF_MAX = GB_DIFF_MAX_DEF,
  parameter logic [PIX_W-1:0] BR_DIFF_MAX = BR_DIFF_MAX_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  red,
  input  wire logic [PIX_W-1:0]  green,
  input  wire logic [PIX_W-1:0]  blue,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [MASK_W-1:0]      mask,
  output logic                   red_hit,
  output logic                   blue_hit,
  output logic                   yellow_hit,
  output logic                   achromatic,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [THR_W-1:0]  cfg_data
);

  ohta_cfg_t cfg;

  ohta_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic ready1, ready2, ready3, ready4;
  logic v1, v2, v3;

  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // stage 1: intensity, differences, achromatic test
  logic [INT_W-1:0]       inten_c;
  logic signed [D1_W-1:0] d1_c;
  logic signed [D2_W-1:0] d2_c;
  logic signed [D1_W-1:0] dgb_c, dbr_c;
  logic [D1_W-1:0]        arg_c, agb_c, abr_c;
  logic                   achro_c;

  always_comb begin
    inten_c = INT_W'(red) + INT_W'(green) + INT_W'(blue);
    d1_c    = $signed({1'b0, red}) - $signed({1'b0, green});
    dgb_c   = $signed({1'b0, green}) - $signed({1'b0, blue});
    dbr_c   = $signed({1'b0, blue}) - $signed({1'b0, red});
    d2_c    = $signed({2'b00, green} << 1) - $signed({2'b00, blue})
              - $signed({2'b00, red});
    arg_c   = d1_c[D1_W-1]  ? D1_W'(-d1_c)  : D1_W'(d1_c);
    agb_c   = dgb_c[D1_W-1] ? D1_W'(-dgb_c) : D1_W'(dgb_c);
    abr_c   = dbr_c[D1_W-1] ? D1_W'(-dbr_c) : D1_W'(dbr_c);
    achro_c = (inten_c < cfg.light_min) || (inten_c == '0)
              || ((arg_c <= {1'b0, RG_DIFF_MAX}) && (agb_c <= {1'b0, GB_DIFF_MAX})
                  && (abr_c <= {1'b0, BR_DIFF_MAX}));
  end

  logic [INT_W-1:0]       inten1;
  logic signed [D1_W-1:0] d1_1;
  logic signed [D2_W-1:0] d2_1;
  logic                   achro1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      inten1 <= inten_c;
      d1_1   <= d1_c;
      d2_1   <= d2_c;
      achro1 <= achro_c;
    end
  end

  // stage 2: threshold products and difference squares
  logic signed [2*D1_W-1:0] d1sq_full;
  logic signed [2*D2_W-1:0] d2sq_full;

  assign d1sq_full = d1_1 * d1_1;
  assign d2sq_full = d2_1 * d2_1;

  logic signed [PROD_W-1:0] prod2 [THR_N];
  logic [D1SQ_W-1:0]        d1sq2;
  logic [D2SQ_W-1:0]        d2sq2;
  logic                     a1_neg2, a1_zero2, a2_neg2, a2_zero2;
  logic                     achro2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      for (int k = 0; k < THR_N; k++) begin
        prod2[k] <= $signed(cfg.thr[k]) * $signed({1'b0, inten1});
      end
      d1sq2    <= d1sq_full[D1SQ_W-1:0];
      d2sq2    <= d2sq_full[D2SQ_W-1:0];
      a1_neg2  <= d1_1[D1_W-1];
      a1_zero2 <= (d1_1 == '0);
      a2_neg2  <= d2_1[D2_W-1];
      a2_zero2 <= (d2_1 == '0);
      achro2   <= achro1;
    end
  end

  // stage 3: squares of the threshold products
  logic [BSQ_W-1:0]  bsq3 [THR_N];
  logic [THR_N-1:0]  b_neg3, b_zero3;
  logic [D1SQ_W-1:0] d1sq3;
  logic [D2SQ_W-1:0] d2sq3;
  logic              a1_neg3, a1_zero3, a2_neg3, a2_zero3;
  logic              achro3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      for (int k = 0; k < THR_N; k++) begin
        bsq3[k]    <= sq_prod(prod2[k]);
        b_neg3[k]  <= prod2[k][PROD_W-1];
        b_zero3[k] <= (prod2[k] == '0);
      end
      d1sq3    <= d1sq2;
      d2sq3    <= d2sq2;
      a1_neg3  <= a1_neg2;
      a1_zero3 <= a1_zero2;
      a2_neg3  <= a2_neg2;
      a2_zero3 <= a2_zero2;
      achro3   <= achro2;
    end
  end

  // stage 4: compare a^2 against k*b^2 and combine signs
  logic [CMP_W-1:0] asq1, asq2;
  logic [CMP_W-1:0] kbsq [THR_N];
  logic [THR_N-1:0] gt_mag, lt_mag;
  ohta_cmp_t        c_rp1, c_rp2, c_bp1, c_bp2, c_bn2, c_yp1, c_yp2, c_yn2;
  logic             rh_c, bh_c, yh_c;

  always_comb begin
    asq1 = CMP_W'({d1sq3, {SCALE_SH{1'b0}}});
    asq2 = CMP_W'({d2sq3, {SCALE_SH{1'b0}}});
    for (int k = 0; k < THR_N; k++) begin
      if (k == THR_RED_P1 || k == THR_BLUE_P1 || k == THR_YELLOW_P1) begin
        kbsq[k]   = CMP_W'({bsq3[k], 1'b0});
        gt_mag[k] = asq1 > kbsq[k];
        lt_mag[k] = asq1 < kbsq[k];
      end else begin
        kbsq[k]   = CMP_W'({bsq3[k], 2'b00}) + CMP_W'({bsq3[k], 1'b0});
        gt_mag[k] = asq2 > kbsq[k];
        lt_mag[k] = asq2 < kbsq[k];
      end
    end

    c_rp1 = root_cmp(a1_neg3, a1_zero3, b_neg3[THR_RED_P1], b_zero3[THR_RED_P1],
                     gt_mag[THR_RED_P1], lt_mag[THR_RED_P1]);
    c_rp2 = root_cmp(a2_neg3, a2_zero3, b_neg3[THR_RED_P2], b_zero3[THR_RED_P2],
                     gt_mag[THR_RED_P2], lt_mag[THR_RED_P2]);
    c_bp1 = root_cmp(a1_neg3, a1_zero3, b_neg3[THR_BLUE_P1], b_zero3[THR_BLUE_P1],
                     gt_mag[THR_BLUE_P1], lt_mag[THR_BLUE_P1]);
    c_bp2 = root_cmp(a2_neg3, a2_zero3, b_neg3[THR_BLUE_P2], b_zero3[THR_BLUE_P2],
                     gt_mag[THR_BLUE_P2], lt_mag[THR_BLUE_P2]);
    c_bn2 = root_cmp(a2_neg3, a2_zero3,
                     !b_neg3[THR_BLUE_P2] && !b_zero3[THR_BLUE_P2],
                     b_zero3[THR_BLUE_P2],
                     gt_mag[THR_BLUE_P2], lt_mag[THR_BLUE_P2]);
    c_yp1 = root_cmp(a1_neg3, a1_zero3, b_neg3[THR_YELLOW_P1], b_zero3[THR_YELLOW_P1],
                     gt_mag[THR_YELLOW_P1], lt_mag[THR_YELLOW_P1]);
    c_yp2 = root_cmp(a2_neg3, a2_zero3, b_neg3[THR_YELLOW_P2], b_zero3[THR_YELLOW_P2],
                     gt_mag[THR_YELLOW_P2], lt_mag[THR_YELLOW_P2]);
    c_yn2 = root_cmp(a2_neg3, a2_zero3,
                     !b_neg3[THR_YELLOW_P2] && !b_zero3[THR_YELLOW_P2],
                     b_zero3[THR_YELLOW_P2],
                     gt_mag[THR_YELLOW_P2], lt_mag[THR_YELLOW_P2]);

    rh_c = !achro3 && cfg.enable[EN_RED] && !c_rp1.lt && !c_rp2.gt;
    bh_c = !achro3 && cfg.enable[EN_BLUE] && !c_bp1.gt && !c_bp2.gt && !c_bn2.lt;
    yh_c = !achro3 && cfg.enable[EN_YELLOW] && !c_yp1.lt && !c_yp2.gt && !c_yn2.lt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      red_hit    <= rh_c;
      blue_hit   <= bh_c;
      yellow_hit <= yh_c;
      achromatic <= achro3;
      mask       <= (rh_c || bh_c || yh_c) ? {MASK_W{1'b1}} : '0;
    end
  end

endmodule

`default_nettype wire

// File: design/ohta_cfg_regs.sv
// ohta_cfg_regs: threshold, light limit and colour enable registers
// depends on ohta_pkg
`default_nettype none

module ohta_cfg_regs
  import ohta_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [THR_W-1:0]    cfg_data,
  output ohta_cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr[THR_RED_P1]    <= RST_RED_P1_MIN;
      cfg.thr[THR_RED_P2]    <= RST_RED_P2_MAX;
      cfg.thr[THR_BLUE_P1]   <= RST_BLUE_P1_MAX;
      cfg.thr[THR_BLUE_P2]   <= RST_BLUE_P2_ABS_MAX;
      cfg.thr[THR_YELLOW_P1] <= RST_YELLOW_P1_MIN;
      cfg.thr[THR_YELLOW_P2] <= RST_YELLOW_P2_ABS_MAX;
      cfg.light_min          <= RST_LIGHT_MIN;
      cfg.enable             <= RST_COLOR_ENABLE;
    end else if (cfg_valid) begin
      case (ohta_reg_t'(cfg_index))
        REG_RED_P1_MIN:        cfg.thr[THR_RED_P1]    <= cfg_data;
        REG_RED_P2_MAX:        cfg.thr[THR_RED_P2]    <= cfg_data;
        REG_BLUE_P1_MAX:       cfg.thr[THR_BLUE_P1]   <= cfg_data;
        REG_BLUE_P2_ABS_MAX:   cfg.thr[THR_BLUE_P2]   <= cfg_data;
        REG_YELLOW_P1_MIN:     cfg.thr[THR_YELLOW_P1] <= cfg_data;
        REG_YELLOW_P2_ABS_MAX: cfg.thr[THR_YELLOW_P2] <= cfg_data;
        REG_LIGHT_MIN:         cfg.light_min          <= cfg_data[LIGHT_W-1:0];
        REG_COLOR_ENABLE:      cfg.enable             <= cfg_data[EN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/ohta_color_pixel_classifier_chk.sv
// ohta_chk: port-level checks on the ohta colour pixel classifier, bound to
// the top level; depends on ohta_pkg
`default_nettype none

module ohta_chk
  import ohta_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [MASK_W-1:0] mask,
  input wire logic              red_hit,
  input wire logic              blue_hit,
  input wire logic              yellow_hit,
  input wire logic              achromatic
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_mask_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((mask == {MASK_W{1'b1}}) == (red_hit || blue_hit || yellow_hit))
                  && ((mask == {MASK_W{1'b1}}) || (mask == '0)))
    else $error("mask does not match hit bits");

  a_achro_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && achromatic |-> !red_hit && !blue_hit && !yellow_hit)
    else $error("hit on achromatic pixel");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mask) && $stable(achromatic))
    else $error("stalled result dropped or changed");

endmodule

bind ohta_color_pixel_classifier ohta_chk u_ohta_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .mask       (mask),
  .red_hit    (red_hit),
  .blue_hit   (blue_hit),
  .yellow_hit (yellow_hit),
  .achromatic (achromatic)
);

`default_nettype wire
